// ===== design/ssec_pkg.sv =====
// Shared types, codes and helper functions of the six/seven/eight-bit character codec.
`timescale 1ns / 1ps
package ssec_pkg;

  // Register indices on the configuration port (byte address divided by four)
  localparam int unsigned CfgAddrWidth = 4;
  localparam logic [1:0] REG_DIRECTION  = 2'd0;
  localparam logic [1:0] REG_CODING     = 2'd1;
  localparam logic [1:0] REG_ENCRYPTION = 2'd2;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [1:0] MODE_ASCII8 = 2'd0;
  localparam logic [1:0] MODE_UTF8   = 2'd1;
  localparam logic [1:0] MODE_ASCII7 = 2'd2;
  localparam logic [1:0] MODE_SIXBIT = 2'd3;

  // Any encryption mode other than none is unsupported.
  localparam logic [1:0] ENC_NONE = 2'd0;

  localparam int unsigned DefaultMaxChars = 256;
  localparam int unsigned FifoDepth       = 4;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_INVALID_CHAR = 2'd1,
    ERR_ENCRYPTION   = 2'd2,
    ERR_OVERFLOW     = 2'd3
  } err_t;

  typedef struct packed {
    logic       direction;
    logic [1:0] coding_mode;
    logic [1:0] encryption_mode;
  } cfg_t;

  typedef struct packed {
    err_t       error_code;
    logic       last;
    logic [3:0] valid_bits;
    logic [7:0] data;
  } result_t;

  // Up to two results written into the output queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    result_t    res1;
    result_t    res0;
  } push_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] code;
  } six_enc_t;

  function automatic logic [14:0] low_mask(input logic [3:0] n);
    logic [14:0] m;
    m = 15'h7FFF << n;
    return ~m;
  endfunction

  function automatic logic [3:0] code_len(input logic [1:0] mode);
    logic [3:0] len;
    case (mode)
      MODE_ASCII8, MODE_UTF8: len = 4'd8;
      MODE_ASCII7:            len = 4'd7;
      MODE_SIXBIT:            len = 4'd6;
      default:                len = 4'd8;
    endcase
    return len;
  endfunction

  // Six-bit encoding: lower case letters are folded to upper case first.
  function automatic six_enc_t sixbit_encode(input logic [7:0] ch);
    six_enc_t   r;
    logic [7:0] c;
    c = ch;
    if (c >= 8'h61 && c <= 8'h7A) begin
      c = c - 8'h20;
    end
    r.ok   = 1'b1;
    r.code = 6'd0;
    if (c >= 8'h40 && c <= 8'h5F) begin
      r.code = 6'(c - 8'h40);
    end else if (c >= 8'h20 && c <= 8'h3F) begin
      r.code = c[5:0];
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Codes below 32 stand for the characters from '@' upwards.
  function automatic logic [7:0] sixbit_decode(input logic [7:0] c, input logic [1:0] mode);
    logic [7:0] r;
    r = c;
    if (mode == MODE_SIXBIT && c < 8'd32) begin
      r = c + 8'h40;
    end
    return r;
  endfunction

endpackage

// ===== design/six_seven_eight_bit_char_codec_top.sv =====
// Top level of the six/seven/eight-bit character codec.
`timescale 1ns / 1ps
// The codec packs characters into a bit stream, most significant bit first, as
// eight-bit, seven-bit or six-bit codes (encode), or cuts a packed stream back
// into characters (decode). Direction, coding mode and encryption mode are set
// through the APB-style port at byte addresses 0, 4 and 8. The user must write
// them only while the block is idle; the block does not enforce this. The pready
// output is always high. Input words arrive on the s_ channel: a character or a
// packed byte with its count of valid leading bits, and s_tlast on the final
// word of a message. Each input word gives zero, one or two result words on the
// m_ channel; the final word of a message always gives at least one, carrying
// m_tlast. Every result word carries the sticky error code as it stands after
// its input word. An accepted word waits in the input register until the
// four-entry queue has room, and its results are then written into the queue,
// which offers them on the m_ side. The core logic takes one input word per
// cycle while the queue has room; the rate is bounded by the output side
// draining one result word per cycle. When the receiver stalls the queue fills,
// and s_tready falls while a word waits in the input register and fewer than
// two entries are free; no result is lost.
// A synchronous reset clears the configuration, the queue and all message
// state (bit accumulator, fill count, character count and sticky error).
module six_seven_eight_bit_char_codec_top
  import ssec_pkg::*;
#(
  parameter int unsigned MAX_CHARS = DefaultMaxChars
) (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // Input words
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // [7:0] in_byte, [11:8] in_valid_bits, [15:12] zero
  input  logic [15:0]             s_tdata,
  input  logic                    s_tlast,
  // Result words
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // [7:0] out_byte, [11:8] out_valid_bits, [13:12] error_code, [15:14] zero
  output logic [15:0]             m_tdata,
  output logic                    m_tlast
);

  cfg_t    cfg;
  push_t   push;
  logic    room;
  result_t out_res;

  ssec_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssec_core #(
    .MAX_CHARS (MAX_CHARS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_byte       (s_tdata[7:0]),
    .in_valid_bits (s_tdata[11:8]),
    .in_last       (s_tlast),
    .room          (room),
    .push          (push)
  );

  ssec_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // Result word layout on the master side
  assign m_tdata = {2'b00, out_res.error_code, out_res.valid_bits, out_res.data};
  assign m_tlast = out_res.last;

endmodule

// ===== design/ssec_cfg.sv =====
// APB-style configuration registers of the character codec.
`timescale 1ns / 1ps
module ssec_cfg
  import ssec_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DIRECTION:  cfg.direction       <= pwdata[0];
        REG_CODING:     cfg.coding_mode     <= pwdata[1:0];
        REG_ENCRYPTION: cfg.encryption_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DIRECTION:  prdata = {31'd0, cfg.direction};
      REG_CODING:     prdata = {30'd0, cfg.coding_mode};
      REG_ENCRYPTION: prdata = {30'd0, cfg.encryption_mode};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/ssec_core.sv =====
// Input register, bit accumulator state and the single-pass encode/decode logic.
`timescale 1ns / 1ps
module ssec_core
  import ssec_pkg::*;
#(
  parameter int unsigned MAX_CHARS = DefaultMaxChars
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic [3:0] in_valid_bits,
  input  logic       in_last,
  input  logic       room,
  output push_t      push
);

  localparam int unsigned CntWidth = $clog2(MAX_CHARS);
  localparam logic [CntWidth-1:0] CharLimit = CntWidth'(MAX_CHARS - 1);

  // Input register
  logic       held_valid;
  logic [7:0] held_byte;
  logic [3:0] held_vb;
  logic       held_last;
  logic       advance;

  // Message state
  logic [14:0]         acc;
  logic [3:0]          fill;
  logic [CntWidth-1:0] chars;
  err_t                err_held;
  logic [14:0]         acc_next;
  logic [3:0]          fill_next;
  logic [CntWidth-1:0] chars_next;
  err_t                err_next;

  // Working signals
  logic [3:0]          len;
  six_enc_t            six;
  logic                enc_ok;
  logic [7:0]          enc_code;
  logic [14:0]         e_acc1, e_acc2;
  logic [3:0]          e_fill1, e_fill2;
  logic                e_emit;
  logic [7:0]          e_byte, e_flush;
  logic [3:0]          vbc;
  logic [14:0]         d_acc1;
  logic [3:0]          d_fill1, d_fill_a, d_fill_b;
  logic                d_emit1, d_emit2;
  logic [7:0]          d_c1, d_c2;
  logic                ov1, ov2;
  logic [CntWidth-1:0] chars_a, chars_b;
  logic [1:0]          base_n;
  logic                extra;
  result_t             extra_res;
  result_t             r0, r1;
  logic [1:0]          n;

  assign advance  = held_valid && room;
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
      held_vb   <= in_valid_bits;
      held_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      fill     <= '0;
      chars    <= '0;
      err_held <= ERR_NONE;
    end else if (advance) begin
      acc      <= acc_next;
      fill     <= fill_next;
      chars    <= chars_next;
      err_held <= err_next;
    end
  end

  // Encode path: append one code, release a full byte, flush the rest on the last word.
  always_comb begin
    len      = code_len(cfg.coding_mode);
    six      = sixbit_encode(held_byte);
    enc_ok   = 1'b1;
    enc_code = held_byte;
    case (cfg.coding_mode)
      MODE_ASCII7: enc_ok = !held_byte[7];
      MODE_SIXBIT: begin
        enc_ok   = six.ok;
        enc_code = {2'b00, six.code};
      end
      default: ;
    endcase
    if (enc_ok) begin
      e_acc1  = (acc << len) | 15'(enc_code);
      e_fill1 = fill + len;
    end else begin
      e_acc1  = acc;
      e_fill1 = fill;
    end
    e_emit  = e_fill1 >= 4'd8;
    e_byte  = 8'(e_acc1 >> (e_fill1 - 4'd8));
    e_fill2 = e_emit ? e_fill1 - 4'd8 : e_fill1;
    e_acc2  = e_acc1 & low_mask(e_fill2);
    e_flush = 8'(e_acc2 << (4'd8 - e_fill2));
  end

  // Decode path: shift in the leading bits, cut at most two characters.
  always_comb begin
    vbc      = (held_vb > 4'd8) ? 4'd8 : held_vb;
    d_acc1   = 15'({acc, held_byte} >> (4'd8 - vbc));
    d_fill1  = fill + vbc;
    d_emit1  = d_fill1 >= len;
    d_fill_a = d_emit1 ? d_fill1 - len : d_fill1;
    d_emit2  = d_emit1 && (d_fill_a >= len);
    d_fill_b = d_emit2 ? d_fill_a - len : d_fill_a;
    d_c1     = sixbit_decode(8'((d_acc1 >> d_fill_a) & low_mask(len)), cfg.coding_mode);
    d_c2     = sixbit_decode(8'((d_acc1 >> d_fill_b) & low_mask(len)), cfg.coding_mode);
    ov1      = chars >= CharLimit;
    chars_a  = ov1 ? chars : chars + 1'b1;
    ov2      = chars_a >= CharLimit;
    if (d_emit2) begin
      chars_b = ov2 ? chars_a : chars_a + 1'b1;
    end else if (d_emit1) begin
      chars_b = chars_a;
    end else begin
      chars_b = chars;
    end
  end

  // Result assembly and next state
  always_comb begin
    err_next = err_held;
    if (err_next == ERR_NONE && cfg.encryption_mode != ENC_NONE) begin
      err_next = ERR_ENCRYPTION;
    end
    r0 = '0;
    r1 = '0;
    if (cfg.direction == DIR_ENCODE) begin
      if (err_next == ERR_NONE && !enc_ok) begin
        err_next = ERR_INVALID_CHAR;
      end
      base_n        = {1'b0, e_emit};
      r0.data       = e_byte;
      r0.valid_bits = 4'd8;
      acc_next      = e_acc2;
      fill_next     = e_fill2;
      chars_next    = chars;
    end else begin
      if (err_next == ERR_NONE && ((d_emit1 && ov1) || (d_emit2 && ov2))) begin
        err_next = ERR_OVERFLOW;
      end
      base_n        = {1'b0, d_emit1} + {1'b0, d_emit2};
      r0.data       = d_c1;
      r0.valid_bits = 4'd8;
      r1.data       = d_c2;
      r1.valid_bits = 4'd8;
      acc_next      = d_acc1 & low_mask(d_fill_b);
      fill_next     = d_fill_b;
      chars_next    = chars_b;
    end

    // A partial byte on the last word, or an empty end marker if nothing else goes out
    extra     = held_last &&
                (((cfg.direction == DIR_ENCODE) && (e_fill2 != 4'd0)) || (base_n == 2'd0));
    extra_res = '0;
    if (cfg.direction == DIR_ENCODE && e_fill2 != 4'd0) begin
      extra_res.data       = e_flush;
      extra_res.valid_bits = e_fill2;
    end
    n = base_n;
    if (extra) begin
      if (base_n == 2'd0) begin
        r0 = extra_res;
      end else begin
        r1 = extra_res;
      end
      n = base_n + 2'd1;
    end
    if (held_last) begin
      if (n == 2'd1) begin
        r0.last = 1'b1;
      end else if (n == 2'd2) begin
        r1.last = 1'b1;
      end
    end
    r0.error_code = err_next;
    r1.error_code = err_next;

    push.count = advance ? n : 2'd0;
    push.res0  = r0;
    push.res1  = r1;

    if (held_last) begin
      acc_next   = '0;
      fill_next  = '0;
      chars_next = '0;
      err_next   = ERR_NONE;
    end
  end

endmodule

// ===== design/ssec_out_fifo.sv =====
// Small result queue: takes up to two words a cycle, hands out one when the reader is ready.
`timescale 1ns / 1ps
module ssec_out_fifo
  import ssec_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  localparam int unsigned PtrWidth = $clog2(FifoDepth);
  localparam int unsigned CntWidth = $clog2(FifoDepth + 1);

  result_t             entries [FifoDepth];
  logic [PtrWidth-1:0] wr_ptr, rd_ptr;
  logic [CntWidth-1:0] count;
  logic                pop;
  logic [PtrWidth-1:0] wr_ptr_b;

  assign room      = count <= CntWidth'(FifoDepth - 2);
  assign out_valid = count != '0;
  assign out_res   = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_b  = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrWidth'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CntWidth'(push.count) - CntWidth'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.res0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_b] <= push.res1;
    end
  end

endmodule
